### rtl/core/tls_pkg.sv
// tls_pkg: shared types and constants of the traffic light sequencer
// holds opcodes, sequencer states, lamp masks, cycle schedule steps and divider sizing
// no dependencies
package tls_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_FLASH = 2'd1,
      OP_CYCLE = 2'd2,
      OP_SPEED = 2'd3
   } tls_op_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_DIV  = 1'b1
   } tls_state_type;

   typedef enum logic [1:0] {
      WALK_NONE      = 2'd0,
      WALK_PRIMARY   = 2'd1,
      WALK_SECONDARY = 2'd2
   } tls_walk_type;

   // lamp bit masks, bit order matches the result fields
   localparam logic [7:0] L_P_RED  = 8'h01;
   localparam logic [7:0] L_P_YEL  = 8'h02;
   localparam logic [7:0] L_P_GRN  = 8'h04;
   localparam logic [7:0] L_P_WALK = 8'h08;
   localparam logic [7:0] L_S_RED  = 8'h10;
   localparam logic [7:0] L_S_YEL  = 8'h20;
   localparam logic [7:0] L_S_GRN  = 8'h40;
   localparam logic [7:0] L_S_WALK = 8'h80;

   // cycle schedule
   localparam logic [7:0] STEP_P_GO        = 8'd1;
   localparam logic [7:0] STEP_P_WALK_FLSH = 8'd141;
   localparam logic [7:0] STEP_P_YELLOW    = 8'd167;
   localparam logic [7:0] STEP_P_RED       = 8'd174;
   localparam logic [7:0] STEP_S_GO        = 8'd186;
   localparam logic [7:0] STEP_S_WALK_FLSH = 8'd226;
   localparam logic [7:0] STEP_S_YELLOW    = 8'd242;

   localparam logic [15:0] BASE_PERIOD_RESET = 16'd1000;

   // base_period / factor divider: one quotient bit per cycle
   localparam int PERIOD_W  = 16;
   localparam int FACTOR_W  = 7;
   localparam int DIV_CNT_W = $clog2(PERIOD_W);

   // one result item: lamps, mode, step position
   typedef struct packed {
      logic [7:0] step_position;
      logic       cycle_mode;
      logic [7:0] lamps;
   } tls_rsp_type;

   localparam int RSP_W      = $bits(tls_rsp_type);
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

### rtl/core/traffic_light_sequencer_unit.sv
// traffic_light_sequencer_unit: traffic light sequencer with pedestrian walk lamps
// uses tls_pkg for opcodes, lamp masks, schedule steps and the result layout
//
// usage:
//   req channel carries one item: a timer tick or a command (opcode on req_tuser,
//   speed factor on req_tdata). rsp channel returns one item per request: the
//   lamp state, mode and step position after that request. csr channel writes
//   base_period, which also resets the step period to factor one.
// throughput:
//   ticks and mode commands are queued in the cycle the item is accepted, so
//   ticks sustain one item per cycle while the output queue has a free entry.
//   an accepted speed factor (1..MAX_SPEED_FACTOR) runs a restoring divider of
//   base_period by the factor, one quotient bit per cycle, then the result is
//   queued; req_tready and csr_ready are low meanwhile.
// stall:
//   results wait in a two-entry output queue; new items are taken while the
//   queue has a free entry, so one stalled result does not block the input.
// reset:
//   flash mode, all lamps off, step 0, prescaler 0, base_period and step
//   period 1000, output queue empty.
module traffic_light_sequencer_unit #(
   parameter int CYCLE_STEPS      = 249,
   parameter int MAX_SPEED_FACTOR = 100
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [6:0] speed_factor, [7] zero
   input  logic [1:0]                      req_tuser,  // [1:0] opcode
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] primary_red, [1] primary_yellow, [2] primary_green, [3] primary_walk,
   // [4] secondary_red, [5] secondary_yellow, [6] secondary_green,
   // [7] secondary_walk, [8] cycle_mode, [16:9] step_position, [23:17] zero
   output logic [tls_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [15:0]                     csr_data    // [15:0] base_period
);

   localparam int PW = tls_pkg::PERIOD_W;
   localparam int FW = tls_pkg::FACTOR_W;
   localparam int CW = tls_pkg::DIV_CNT_W;

   // architectural state
   tls_pkg::tls_state_type state_ff, state_in;
   logic [PW-1:0]          base_ff, base_in;
   logic [PW-1:0]          step_period_ff, step_period_in;
   logic [PW-1:0]          prescale_ff, prescale_in;
   logic                   mode_ff, mode_in;
   logic [7:0]             step_ff, step_in;
   tls_pkg::tls_walk_type  walk_ff, walk_in;
   logic [7:0]             lamps_ff, lamps_in;

   // divider
   logic [PW-1:0] div_quo_ff, div_quo_in;
   logic [FW-1:0] div_rem_ff, div_rem_in;
   logic [FW-1:0] div_den_ff, div_den_in;
   logic [CW-1:0] div_cnt_ff, div_cnt_in;

   // output queue
   tls_pkg::tls_rsp_type q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]           qcnt_ff, qcnt_in;

   logic                 req_fire, rsp_fire, csr_fire, push;
   tls_pkg::tls_rsp_type push_item;
   tls_pkg::tls_op_type  opcode;
   logic [FW-1:0]        factor;
   logic [PW-1:0]        eff_base, period, pres_inc;
   logic [7:0]           step_inc;
   logic [7:0]           lamp_on, lamp_off, lamps_adv;
   tls_pkg::tls_walk_type walk_adv;
   logic [FW:0]          rem_sh;
   logic                 quo_bit;
   logic [PW-1:0]        quo_next;

   assign opcode     = tls_pkg::tls_op_type'(req_tuser);
   assign factor     = req_tdata[FW-1:0];
   assign req_tready = (state_ff == tls_pkg::ST_IDLE) && (qcnt_ff != 2'd2);
   assign csr_ready  = (state_ff == tls_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_tvalid = (qcnt_ff != 2'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {{(tls_pkg::RSP_DATA_W - tls_pkg::RSP_W){1'b0}}, q0_ff};

   assign eff_base = (base_ff == '0) ? {{(PW-1){1'b0}}, 1'b1} : base_ff;
   assign period   = mode_ff ? step_period_ff : eff_base;
   assign pres_inc = (prescale_ff == '1) ? prescale_ff : prescale_ff + 1'b1;

   // divider step: shift in the next dividend bit, trial subtract
   assign rem_sh   = {div_rem_ff, div_quo_ff[PW-1]};
   assign quo_bit  = (rem_sh >= {1'b0, div_den_ff});
   assign quo_next = {div_quo_ff[PW-2:0], quo_bit};

   // one step of the signal schedule
   always_comb begin
      lamp_on  = '0;
      lamp_off = '0;
      walk_adv = walk_ff;
      step_inc = step_ff + 8'd1;
      case (step_inc)
         tls_pkg::STEP_P_GO: begin
            walk_adv = tls_pkg::WALK_NONE;
            lamp_on  = tls_pkg::L_P_GRN | tls_pkg::L_P_WALK | tls_pkg::L_S_RED;
            lamp_off = tls_pkg::L_S_WALK | tls_pkg::L_S_YEL | tls_pkg::L_P_RED;
         end
         tls_pkg::STEP_P_WALK_FLSH: begin
            walk_adv = tls_pkg::WALK_PRIMARY;
         end
         tls_pkg::STEP_P_YELLOW: begin
            walk_adv = tls_pkg::WALK_NONE;
            lamp_on  = tls_pkg::L_P_YEL;
            lamp_off = tls_pkg::L_P_GRN | tls_pkg::L_P_WALK;
         end
         tls_pkg::STEP_P_RED: begin
            lamp_on  = tls_pkg::L_P_RED;
            lamp_off = tls_pkg::L_P_YEL;
         end
         tls_pkg::STEP_S_GO: begin
            lamp_on  = tls_pkg::L_S_GRN | tls_pkg::L_S_WALK;
            lamp_off = tls_pkg::L_S_RED;
         end
         tls_pkg::STEP_S_WALK_FLSH: begin
            walk_adv = tls_pkg::WALK_SECONDARY;
         end
         tls_pkg::STEP_S_YELLOW: begin
            walk_adv = tls_pkg::WALK_NONE;
            lamp_on  = tls_pkg::L_S_YEL;
            lamp_off = tls_pkg::L_S_GRN;
         end
         default: begin
         end
      endcase
      lamps_adv = (lamps_ff & ~lamp_off) | lamp_on;
      case (walk_adv)
         tls_pkg::WALK_PRIMARY:   lamps_adv = lamps_adv ^ tls_pkg::L_P_WALK;
         tls_pkg::WALK_SECONDARY: lamps_adv = lamps_adv ^ tls_pkg::L_S_WALK;
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      step_period_in = step_period_ff;
      prescale_in    = prescale_ff;
      mode_in        = mode_ff;
      step_in        = step_ff;
      walk_in        = walk_ff;
      lamps_in       = lamps_ff;
      div_quo_in     = div_quo_ff;
      div_rem_in     = div_rem_ff;
      div_den_in     = div_den_ff;
      div_cnt_in     = div_cnt_ff;
      push           = 1'b0;

      case (state_ff)
         tls_pkg::ST_IDLE: begin
            if (csr_fire) begin
               base_in        = csr_data;
               step_period_in = (csr_data == '0) ? {{(PW-1){1'b0}}, 1'b1} : csr_data;
            end
            if (req_fire) begin
               case (opcode)
                  tls_pkg::OP_TICK: begin
                     push        = 1'b1;
                     prescale_in = pres_inc;
                     if (pres_inc >= period) begin
                        prescale_in = '0;
                        if (mode_ff) begin
                           step_in  = (step_inc >= 8'(CYCLE_STEPS)) ? 8'd0 : step_inc;
                           walk_in  = walk_adv;
                           lamps_in = lamps_adv;
                        end else begin
                           lamps_in = lamps_ff ^ (tls_pkg::L_P_RED | tls_pkg::L_S_RED);
                        end
                     end
                  end
                  tls_pkg::OP_FLASH: begin
                     push        = 1'b1;
                     mode_in     = 1'b0;
                     walk_in     = tls_pkg::WALK_NONE;
                     prescale_in = '0;
                     lamps_in    = '0;
                  end
                  tls_pkg::OP_CYCLE: begin
                     push        = 1'b1;
                     mode_in     = 1'b1;
                     walk_in     = tls_pkg::WALK_NONE;
                     step_in     = '0;
                     prescale_in = '0;
                     lamps_in    = '0;
                  end
                  default: begin
                     if (factor != '0 && factor <= FW'(MAX_SPEED_FACTOR)) begin
                        state_in   = tls_pkg::ST_DIV;
                        div_quo_in = eff_base;
                        div_rem_in = '0;
                        div_den_in = factor;
                        div_cnt_in = '0;
                     end else begin
                        push = 1'b1;
                     end
                  end
               endcase
            end
         end
         default: begin
            div_quo_in = quo_next;
            div_rem_in = quo_bit ? FW'(rem_sh - {1'b0, div_den_ff}) : rem_sh[FW-1:0];
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == CW'(PW - 1)) begin
               state_in       = tls_pkg::ST_IDLE;
               step_period_in = (quo_next == '0) ? {{(PW-1){1'b0}}, 1'b1} : quo_next;
               push           = 1'b1;
            end
         end
      endcase
   end

   assign push_item = '{step_position: step_in, cycle_mode: mode_in, lamps: lamps_in};

   // two-entry output queue, q0 is the head
   always_comb begin
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      qcnt_in = qcnt_ff;
      case ({push, rsp_fire})
         2'b10: begin
            if (qcnt_ff == 2'd0) q0_in = push_item;
            else                 q1_in = push_item;
            qcnt_in = qcnt_ff + 2'd1;
         end
         2'b01: begin
            q0_in   = q1_ff;
            qcnt_in = qcnt_ff - 2'd1;
         end
         2'b11: begin
            if (qcnt_ff == 2'd1) begin
               q0_in = push_item;
            end else begin
               q0_in = q1_ff;
               q1_in = push_item;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tls_pkg::ST_IDLE;
         base_ff        <= tls_pkg::BASE_PERIOD_RESET;
         step_period_ff <= tls_pkg::BASE_PERIOD_RESET;
         prescale_ff    <= '0;
         mode_ff        <= 1'b0;
         step_ff        <= '0;
         walk_ff        <= tls_pkg::WALK_NONE;
         lamps_ff       <= '0;
         qcnt_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         base_ff        <= base_in;
         step_period_ff <= step_period_in;
         prescale_ff    <= prescale_in;
         mode_ff        <= mode_in;
         step_ff        <= step_in;
         walk_ff        <= walk_in;
         lamps_ff       <= lamps_in;
         qcnt_ff        <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_quo_ff <= div_quo_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
   end

endmodule

### rtl/core/tls_checker.sv
// tls_checker: port-level assertions for traffic_light_sequencer_unit
// bound to the top level below; uses tls_pkg for lamp masks and the result width
module tls_checker #(
   parameter int CYCLE_STEPS      = 249,
   parameter int MAX_SPEED_FACTOR = 100
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [7:0]                     req_tdata,
   input logic [1:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           csr_ready
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // step position stays inside the cycle
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:9] < 8'(CYCLE_STEPS))
      else $error("step position out of cycle range");

   // in flash mode only the red lamps can be lit
   a_flash_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |->
         (rsp_tdata[7:0] & ~(tls_pkg::L_P_RED | tls_pkg::L_S_RED)) == 8'd0)
      else $error("non-red lamp lit in flash mode");

   // an accepted speed factor starts the divider: both inputs stall next cycle
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == tls_pkg::OP_SPEED &&
      req_tdata[6:0] != 7'd0 && req_tdata[6:0] <= 7'(MAX_SPEED_FACTOR)
      |=> !req_tready && !csr_ready)
      else $error("item or write taken during speed factor division");

   // padding above the result fields is zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[tls_pkg::RSP_DATA_W-1:tls_pkg::RSP_W] == '0)
      else $error("result padding not zero");

endmodule

bind traffic_light_sequencer_unit tls_checker #(
   .CYCLE_STEPS      (CYCLE_STEPS),
   .MAX_SPEED_FACTOR (MAX_SPEED_FACTOR)
) u_tls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
